@@ rtl/core/dpso_pkg.sv @@
package dpso_pkg;

  localparam int unsigned IntervalW = 22;
  localparam int unsigned ShiftMagW = 7;
  localparam int unsigned ShiftW    = 8;
  localparam int unsigned CoordW    = 16;
  localparam int unsigned StepW     = 4;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(300000);
  localparam logic [IntervalW-1:0] IntervalMin   = IntervalW'(1000);
  localparam logic [ShiftMagW-1:0] ShiftReset    = ShiftMagW'(2);
  localparam logic [ShiftMagW-1:0] ShiftMin      = ShiftMagW'(2);
  localparam logic [StepW-1:0]     StepLast      = StepW'(8);

  localparam logic [2:0] OpTick  = 3'd0;
  localparam logic [2:0] OpStart = 3'd1;
  localparam logic [2:0] OpStop  = 3'd2;
  localparam logic [2:0] OpReset = 3'd3;
  localparam logic [2:0] OpMap   = 3'd4;

  localparam logic [CfgIdxW-1:0] RegInterval = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMaxShift = CfgIdxW'(1);

  localparam logic [1:0] UnitZero = 2'b00;
  localparam logic [1:0] UnitPos  = 2'b01;
  localparam logic [1:0] UnitNeg  = 2'b11;

  typedef struct packed {
    logic signed [ShiftW-1:0] shift_x;
    logic signed [ShiftW-1:0] shift_y;
    logic                     running;
    logic                     changed;
  } dpso_status_t;

  function automatic logic [1:0] orbit_unit_x(input logic [StepW-1:0] step);
    logic [1:0] u;
    case (step)
      4'd1, 4'd2, 4'd8: u = UnitPos;
      4'd4, 4'd5, 4'd6: u = UnitNeg;
      default:          u = UnitZero;
    endcase
    return u;
  endfunction

  function automatic logic [1:0] orbit_unit_y(input logic [StepW-1:0] step);
    logic [1:0] u;
    case (step)
      4'd2, 4'd3, 4'd4: u = UnitPos;
      4'd6, 4'd7, 4'd8: u = UnitNeg;
      default:          u = UnitZero;
    endcase
    return u;
  endfunction

  function automatic logic signed [ShiftW-1:0] scale_unit(input logic [1:0] u,
                                                          input logic [ShiftMagW-1:0] mag);
    logic signed [ShiftW-1:0] v;
    case (u)
      UnitPos: v = signed'({1'b0, mag});
      UnitNeg: v = signed'(ShiftW'(0) - {1'b0, mag});
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/dpso_cfg.sv @@
module dpso_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [dpso_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [dpso_pkg::IntervalW-1:0]     cfg_wdata,
  output logic [dpso_pkg::IntervalW-1:0]     interval_ms,
  output logic [dpso_pkg::ShiftMagW-1:0]     max_shift
);

  logic [dpso_pkg::IntervalW-1:0] interval_r, interval_nxt;
  logic [dpso_pkg::ShiftMagW-1:0] shift_r, shift_nxt;
  logic [dpso_pkg::ShiftMagW-1:0] shift_raw;

  assign shift_raw = cfg_wdata[dpso_pkg::ShiftMagW-1:0];

  always_comb begin
    interval_nxt = interval_r;
    shift_nxt    = shift_r;
    if (cfg_we && cfg_index == dpso_pkg::RegInterval) begin
      interval_nxt = (cfg_wdata < dpso_pkg::IntervalMin) ? dpso_pkg::IntervalMin : cfg_wdata;
    end
    if (cfg_we && cfg_index == dpso_pkg::RegMaxShift) begin
      shift_nxt = (shift_raw < dpso_pkg::ShiftMin) ? dpso_pkg::ShiftMin
                                                   : {shift_raw[dpso_pkg::ShiftMagW-1:1], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= dpso_pkg::IntervalReset;
      shift_r    <= dpso_pkg::ShiftReset;
    end else begin
      interval_r <= interval_nxt;
      shift_r    <= shift_nxt;
    end
  end

  assign interval_ms = interval_r;
  assign max_shift   = shift_r;

endmodule

@@ rtl/core/dpso_orbit.sv @@
module dpso_orbit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           accept,
  input  logic [2:0]                     opcode,
  input  logic [dpso_pkg::IntervalW-1:0] interval_ms,
  input  logic [dpso_pkg::ShiftMagW-1:0] max_shift,
  output dpso_pkg::dpso_status_t         status
);

  logic                                  running_r, running_nxt;
  logic [dpso_pkg::IntervalW-1:0]        tick_r, tick_nxt;
  logic [dpso_pkg::StepW-1:0]            step_r, step_nxt;
  logic signed [dpso_pkg::ShiftW-1:0]    sx_r, sx_nxt, sy_r, sy_nxt;
  logic [dpso_pkg::IntervalW-1:0]        tick_inc;
  logic [dpso_pkg::StepW-1:0]            step_inc;
  logic                                  changed;

  assign tick_inc = tick_r + dpso_pkg::IntervalW'(1);
  assign step_inc = (step_r == dpso_pkg::StepLast) ? '0 : step_r + dpso_pkg::StepW'(1);

  always_comb begin
    running_nxt = running_r;
    tick_nxt    = tick_r;
    step_nxt    = step_r;
    sx_nxt      = sx_r;
    sy_nxt      = sy_r;
    changed     = 1'b0;
    case (opcode)
      dpso_pkg::OpTick: begin
        if (running_r) begin
          if (tick_inc >= interval_ms) begin
            tick_nxt = '0;
            step_nxt = step_inc;
            sx_nxt   = dpso_pkg::scale_unit(dpso_pkg::orbit_unit_x(step_inc), max_shift);
            sy_nxt   = dpso_pkg::scale_unit(dpso_pkg::orbit_unit_y(step_inc), max_shift);
            changed  = 1'b1;
          end else begin
            tick_nxt = tick_inc;
          end
        end
      end
      dpso_pkg::OpStart: begin
        if (!running_r) begin
          running_nxt = 1'b1;
          tick_nxt    = '0;
        end
      end
      dpso_pkg::OpStop: begin
        if (running_r) begin
          running_nxt = 1'b0;
          tick_nxt    = '0;
          step_nxt    = '0;
          sx_nxt      = '0;
          sy_nxt      = '0;
        end
      end
      dpso_pkg::OpReset: begin
        step_nxt = '0;
        sx_nxt   = '0;
        sy_nxt   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      tick_r    <= '0;
      step_r    <= '0;
      sx_r      <= '0;
      sy_r      <= '0;
    end else if (accept) begin
      running_r <= running_nxt;
      tick_r    <= tick_nxt;
      step_r    <= step_nxt;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
    end
  end

  assign status.shift_x = sx_nxt;
  assign status.shift_y = sy_nxt;
  assign status.running = running_nxt;
  assign status.changed = changed;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= dpso_pkg::StepLast)
    else $error("orbit step out of range");

  a_home_zero: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == '0 |-> sx_r == '0 && sy_r == '0)
    else $error("offset not zero at home step");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(running_r) |-> step_r == '0 && tick_r == '0)
    else $error("stop left step or counter set");

  a_idle_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r && $past(!running_r) && $past(rst_n) |-> $stable(tick_r))
    else $error("counter moved while stopped");

endmodule

@@ rtl/core/dpso_map.sv @@
module dpso_map (
  input  logic [dpso_pkg::CoordW-1:0]        raw,
  input  logic signed [dpso_pkg::ShiftW-1:0] offset,
  output logic [dpso_pkg::CoordW-1:0]        mapped
);

  logic signed [dpso_pkg::CoordW+1:0] diff;

  assign diff = signed'({2'b00, raw}) - (dpso_pkg::CoordW+2)'(offset);

  always_comb begin
    if (diff < 0) begin
      mapped = '0;
    end else if (diff[dpso_pkg::CoordW]) begin
      mapped = '1;
    end else begin
      mapped = diff[dpso_pkg::CoordW-1:0];
    end
  end

endmodule

@@ rtl/core/display_pixel_shift_orbit_top.sv @@
// Results are registered: out_valid rises in the cycle after acceptance.
// Throughput: one transaction per cycle while out_ready is high; the result
// register refills on the edge where downstream takes the previous result.
// Reset (synchronous, rst_n low): timer stopped, counter, step and offsets
// zero, interval 300000 ticks, shift magnitude 2, no result pending.
module display_pixel_shift_orbit_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_opcode,
  input  logic [dpso_pkg::CoordW-1:0]         in_touch_x,
  input  logic [dpso_pkg::CoordW-1:0]         in_touch_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dpso_pkg::ShiftW-1:0]  out_shift_x,
  output logic signed [dpso_pkg::ShiftW-1:0]  out_shift_y,
  output logic [dpso_pkg::CoordW-1:0]         out_mapped_x,
  output logic [dpso_pkg::CoordW-1:0]         out_mapped_y,
  output logic                                out_timer_on,
  output logic                                out_shift_changed,
  input  logic                                cfg_we,
  input  logic [dpso_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [dpso_pkg::IntervalW-1:0]      cfg_wdata
);

  logic [dpso_pkg::IntervalW-1:0] interval_ms;
  logic [dpso_pkg::ShiftMagW-1:0] max_shift;
  dpso_pkg::dpso_status_t         status;
  logic                           accept;
  logic [dpso_pkg::CoordW-1:0]    mx, my;

  logic                           valid_r;
  dpso_pkg::dpso_status_t         status_r;
  logic [dpso_pkg::CoordW-1:0]    mx_r, my_r;

  assign in_ready = !valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  dpso_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .interval_ms (interval_ms),
    .max_shift   (max_shift)
  );

  dpso_orbit u_orbit (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .opcode      (in_opcode),
    .interval_ms (interval_ms),
    .max_shift   (max_shift),
    .status      (status)
  );

  dpso_map u_map_x (
    .raw    (in_touch_x),
    .offset (status.shift_x),
    .mapped (mx)
  );

  dpso_map u_map_y (
    .raw    (in_touch_y),
    .offset (status.shift_y),
    .mapped (my)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status;
      mx_r     <= mx;
      my_r     <= my;
    end
  end

  assign out_valid         = valid_r;
  assign out_shift_x       = status_r.shift_x;
  assign out_shift_y       = status_r.shift_y;
  assign out_mapped_x      = mx_r;
  assign out_mapped_y      = my_r;
  assign out_timer_on      = status_r.running;
  assign out_shift_changed = status_r.changed;

  a_changed_running: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && status_r.changed |-> status_r.running)
    else $error("shift change reported while stopped");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> valid_r)
    else $error("accepted transaction produced no result");

  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

@@ dv/display_pixel_shift_orbit_top_tb.sv @@
module display_pixel_shift_orbit_top_tb;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned LongHold   = 400;

  typedef struct packed {
    logic [2:0]                  opcode;
    logic [dpso_pkg::CoordW-1:0] touch_x;
    logic [dpso_pkg::CoordW-1:0] touch_y;
  } touch_cmd_t;

  typedef struct packed {
    logic signed [dpso_pkg::ShiftW-1:0] shift_x;
    logic signed [dpso_pkg::ShiftW-1:0] shift_y;
    logic [dpso_pkg::CoordW-1:0]        mapped_x;
    logic [dpso_pkg::CoordW-1:0]        mapped_y;
    logic                               running;
    logic                               changed;
  } offset_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic [2:0]                         in_opcode = dpso_pkg::OpTick;
  logic [dpso_pkg::CoordW-1:0]        in_touch_x = '0;
  logic [dpso_pkg::CoordW-1:0]        in_touch_y = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [dpso_pkg::ShiftW-1:0] out_shift_x;
  logic signed [dpso_pkg::ShiftW-1:0] out_shift_y;
  logic [dpso_pkg::CoordW-1:0]        out_mapped_x;
  logic [dpso_pkg::CoordW-1:0]        out_mapped_y;
  logic                               out_timer_on;
  logic                               out_shift_changed;
  logic                               cfg_we = 1'b0;
  logic [dpso_pkg::CfgIdxW-1:0]       cfg_index = '0;
  logic [dpso_pkg::IntervalW-1:0]     cfg_wdata = '0;

  touch_cmd_t     cmd_q[$];
  offset_result_t offset_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned cmds_sent = 0;
  int unsigned results_checked = 0;
  int unsigned shifts_seen = 0;
  int unsigned mismatches = 0;

  logic [dpso_pkg::IntervalW-1:0] model_interval = dpso_pkg::IntervalReset;
  logic [dpso_pkg::ShiftMagW-1:0] model_mag = dpso_pkg::ShiftReset;
  logic                           model_running = 1'b0;
  logic [dpso_pkg::IntervalW-1:0] model_count = '0;
  int                             model_step = 0;
  int                             model_sx = 0;
  int                             model_sy = 0;

  display_pixel_shift_orbit_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_touch_x        (in_touch_x),
    .in_touch_y        (in_touch_y),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_shift_x       (out_shift_x),
    .out_shift_y       (out_shift_y),
    .out_mapped_x      (out_mapped_x),
    .out_mapped_y      (out_mapped_y),
    .out_timer_on      (out_timer_on),
    .out_shift_changed (out_shift_changed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int orbit_dx(input int step);
    int d;
    case (step)
      1, 2, 8: d = 1;
      4, 5, 6: d = -1;
      default: d = 0;
    endcase
    return d;
  endfunction

  function automatic int orbit_dy(input int step);
    int d;
    case (step)
      2, 3, 4: d = 1;
      6, 7, 8: d = -1;
      default: d = 0;
    endcase
    return d;
  endfunction

  function automatic logic [dpso_pkg::CoordW-1:0] clamp_coord(
      input logic [dpso_pkg::CoordW-1:0] raw, input int off);
    int v;
    v = int'(raw) - off;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return dpso_pkg::CoordW'(v);
  endfunction

  task automatic predict_shift(input touch_cmd_t cmd, output offset_result_t res);
    res = '0;
    case (cmd.opcode)
      dpso_pkg::OpTick: begin
        if (model_running) begin
          model_count = model_count + 1'b1;
          if (model_count >= model_interval) begin
            model_count = '0;
            model_step = (model_step == int'(dpso_pkg::StepLast)) ? 0 : model_step + 1;
            model_sx = orbit_dx(model_step) * int'(model_mag);
            model_sy = orbit_dy(model_step) * int'(model_mag);
            res.changed = 1'b1;
          end
        end
      end
      dpso_pkg::OpStart: begin
        if (!model_running) begin
          model_running = 1'b1;
          model_count = '0;
        end
      end
      dpso_pkg::OpStop: begin
        if (model_running) begin
          model_running = 1'b0;
          model_count = '0;
          model_step = 0;
          model_sx = 0;
          model_sy = 0;
        end
      end
      dpso_pkg::OpReset: begin
        model_step = 0;
        model_sx = 0;
        model_sy = 0;
      end
      default: ;
    endcase
    res.shift_x  = dpso_pkg::ShiftW'(model_sx);
    res.shift_y  = dpso_pkg::ShiftW'(model_sy);
    res.mapped_x = clamp_coord(cmd.touch_x, model_sx);
    res.mapped_y = clamp_coord(cmd.touch_y, model_sy);
    res.running  = model_running;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  // driver: hold the transaction until accepted, predict on acceptance
  always @(posedge clk) begin
    offset_result_t res;
    touch_cmd_t     cmd;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_shift('{in_opcode, in_touch_x, in_touch_y}, res);
        offset_q.push_back(res);
        cmds_sent++;
      end
      if (!in_valid || in_ready) begin
        if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cmd = cmd_q.pop_front();
          in_opcode  <= cmd.opcode;
          in_touch_x <= cmd.touch_x;
          in_touch_y <= cmd.touch_y;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served && out_valid) begin
      out_ready   <= 1'b0;
      hold_left   <= LongHold;
      hold_served <= hold_served + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    offset_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (offset_q.size() == 0) begin
        $error("result transaction with no expectation pending");
        mismatches++;
      end else begin
        want = offset_q.pop_front();
        check_field("shift_x", 32'(want.shift_x), 32'(out_shift_x));
        check_field("shift_y", 32'(want.shift_y), 32'(out_shift_y));
        check_field("mapped_x", 32'(want.mapped_x), 32'(out_mapped_x));
        check_field("mapped_y", 32'(want.mapped_y), 32'(out_mapped_y));
        check_field("timer_on", 32'(want.running), 32'(out_timer_on));
        check_field("shift_changed", 32'(want.changed), 32'(out_shift_changed));
        results_checked++;
        if (out_shift_changed === 1'b1) shifts_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [dpso_pkg::CoordW-1:0] pick_coord();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel < 2) return '0;
    if (sel < 4) return '1;
    if (sel == 4) return dpso_pkg::CoordW'($urandom_range(0, 130));
    if (sel == 5) return dpso_pkg::CoordW'(65535 - $urandom_range(0, 130));
    return dpso_pkg::CoordW'($urandom);
  endfunction

  task automatic queue_cmd(input logic [2:0] op, input logic [dpso_pkg::CoordW-1:0] tx,
                           input logic [dpso_pkg::CoordW-1:0] ty);
    cmd_q.push_back('{op, tx, ty});
  endtask

  task automatic queue_ticks(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) queue_cmd(dpso_pkg::OpTick, pick_coord(), pick_coord());
  endtask

  task automatic queue_random_mix(input int unsigned n);
    int unsigned sel;
    for (int unsigned i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 48) begin
        queue_cmd(dpso_pkg::OpTick, pick_coord(), pick_coord());
      end else if (sel < 66) begin
        queue_cmd(dpso_pkg::OpMap, pick_coord(), pick_coord());
      end else if (sel < 75) begin
        queue_cmd(dpso_pkg::OpStart, pick_coord(), pick_coord());
      end else if (sel < 81) begin
        queue_cmd(dpso_pkg::OpStop, pick_coord(), pick_coord());
      end else if (sel < 86) begin
        queue_cmd(dpso_pkg::OpReset, pick_coord(), pick_coord());
      end else if (sel < 92) begin
        queue_cmd(dpso_pkg::OpMap + 3'($urandom_range(1, 3)), pick_coord(), pick_coord());
      end else if (sel < 95) begin
        // start, then a short run of ticks
        queue_cmd(dpso_pkg::OpStart, pick_coord(), pick_coord());
        queue_ticks($urandom_range(3, 12));
      end else begin
        queue_cmd(dpso_pkg::OpTick, pick_coord(), pick_coord());
      end
    end
  endtask

  task automatic write_reg(input logic [dpso_pkg::CfgIdxW-1:0] idx,
                           input logic [dpso_pkg::IntervalW-1:0] data);
    logic [dpso_pkg::ShiftMagW-1:0] mag;
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == dpso_pkg::RegInterval) begin
      model_interval = (data < dpso_pkg::IntervalMin) ? dpso_pkg::IntervalMin : data;
    end else if (idx == dpso_pkg::RegMaxShift) begin
      mag = data[dpso_pkg::ShiftMagW-1:0];
      if (mag < dpso_pkg::ShiftMin) mag = dpso_pkg::ShiftMin;
      model_mag = mag & ~dpso_pkg::ShiftMagW'(1);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (cmd_q.size() != 0 || in_valid || offset_q.size() != 0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    queue_cmd(dpso_pkg::OpMap, '0, '0);
    queue_cmd(dpso_pkg::OpMap, '1, '1);
    queue_cmd(dpso_pkg::OpTick, 16'h1234, 16'hFEDC);
    queue_cmd(dpso_pkg::OpStop, 16'h0001, 16'hFFFE);
    queue_cmd(dpso_pkg::OpReset, 16'h8000, 16'h7FFF);
    queue_cmd(dpso_pkg::OpMap + 3'd1, '1, '0);
    queue_cmd(dpso_pkg::OpMap + 3'd2, '0, '1);
    queue_cmd(dpso_pkg::OpMap + 3'd3, 16'hAAAA, 16'h5555);
    queue_cmd(dpso_pkg::OpStart, 16'h0002, 16'h0003);
    queue_cmd(dpso_pkg::OpStart, 16'hFFFD, 16'hFFFC);
    queue_ticks(3);
    queue_cmd(dpso_pkg::OpReset, '0, '1);
    queue_cmd(dpso_pkg::OpStop, '1, '0);
    queue_cmd(dpso_pkg::OpStart, 16'h0100, 16'h0200);
    queue_cmd(dpso_pkg::OpTick, '0, '0);
    wait_drained();

    write_reg(dpso_pkg::RegMaxShift + 2'd1, dpso_pkg::IntervalW'($urandom));
    write_reg(dpso_pkg::RegMaxShift + 2'd2, dpso_pkg::IntervalW'($urandom));
    write_reg(dpso_pkg::RegInterval, '0);
    write_reg(dpso_pkg::RegMaxShift, 22'h3FFF01);
    queue_cmd(dpso_pkg::OpMap, '0, '1);
    queue_ticks(4);
    wait_drained();

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_reg(dpso_pkg::RegMaxShift, 22'd127);
          write_reg(dpso_pkg::RegInterval, 22'd3600000);
          hold_requests = hold_requests + 1;
          queue_cmd(dpso_pkg::OpStop, pick_coord(), pick_coord());
          queue_cmd(dpso_pkg::OpStart, pick_coord(), pick_coord());
          queue_ticks(1005);
          wait_drained();
          // shrink the interval under a counter that is already past it
          write_reg(dpso_pkg::RegInterval, 22'd999);
          queue_cmd(dpso_pkg::OpTick, pick_coord(), pick_coord());
          queue_cmd(dpso_pkg::OpMap, '0, '1);
          queue_ticks(3);
          queue_cmd(dpso_pkg::OpStop, pick_coord(), pick_coord());
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
          write_reg(dpso_pkg::RegInterval, dpso_pkg::IntervalW'($urandom_range(1000, 1200)));
          write_reg(dpso_pkg::RegMaxShift, dpso_pkg::IntervalW'($urandom_range(0, 127)));
          queue_random_mix(25);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
          write_reg(dpso_pkg::RegInterval, dpso_pkg::IntervalW'($urandom_range(0, 1100)));
          write_reg(dpso_pkg::RegMaxShift, dpso_pkg::IntervalW'($urandom));
          queue_random_mix(25);
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
          write_reg(dpso_pkg::RegInterval, dpso_pkg::IntervalW'($urandom_range(1000, 1100)));
          write_reg(dpso_pkg::RegMaxShift, dpso_pkg::IntervalW'($urandom_range(2, 126)));
          queue_random_mix(25);
        end
      endcase
      wait_drained();
    end

    repeat (8) @(posedge clk);
    $display("%0d transactions checked across four flow-control phases, %0d orbit shifts seen",
             results_checked, shifts_seen);
    $display("%0d commands sent, %0d mismatches", cmds_sent, mismatches);
    if (mismatches == 0 && offset_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dpso_pkg.sv
rtl/core/dpso_cfg.sv
rtl/core/dpso_orbit.sv
rtl/core/dpso_map.sv
rtl/core/display_pixel_shift_orbit_top.sv
dv/display_pixel_shift_orbit_top_tb.sv
